FILE: design/fmm_pkg.sv
// Package for the filter modulation matrix: request, response and route types,
// operation codes, and the elaboration-time builder for the 2^x fraction table.
// No dependencies.
`default_nettype none

package fmm_pkg;

  // Operation codes carried in the request.
  localparam logic [2:0] OP_CONNECT    = 3'd0;
  localparam logic [2:0] OP_DISC_ID    = 3'd1;
  localparam logic [2:0] OP_DISC_FILT  = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_SET_SRC    = 3'd4;
  localparam logic [2:0] OP_QUERY      = 3'd5;
  localparam logic [2:0] OP_READ_SRC   = 3'd6;

  // Target kind that takes the exponential path.
  localparam logic [1:0] TGT_CUTOFF = 2'd0;

  // Fixed-point constants.
  localparam logic [15:0] DEPTH_ONE  = 16'd32768;
  localparam int          LVL_ONE    = 16384;
  localparam int          SUM_LIMIT  = 536870912;
  localparam int          ROUND_HALF = 8192;
  localparam int          M_SHIFT    = 14;
  localparam int          M_OFFSET   = 32768;
  localparam int          OUT_MAX    = 32768;
  localparam int          MASK_W     = 7;
  localparam int          EXP_SHIFT  = 32;

  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         source_index;
    logic [1:0]         target_kind;
    logic [2:0]         filter_number;
    logic [15:0]        depth_amount;
    logic               remap_bipolar;
    logic [15:0]        route_id;
    logic signed [15:0] level_in;
    logic [15:0]        base_value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [15:0]        new_route_id;
    logic [17:0]        modulated_value;
    logic signed [15:0] level_out;
    logic [4:0]         route_count;
  } rsp_t;

  // One stored route.
  typedef struct packed {
    logic [2:0]  source;
    logic [1:0]  target;
    logic [2:0]  filter;
    logic        remap;
    logic [15:0] depth;
    logic [15:0] id;
  } route_t;

  // Restoring division, used only on constants while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry k of the table: 2^(k/size) in Q.30 from a truncated Taylor series.
  function automatic logic [31:0] exp_entry(input int k, input int size);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = udiv64(64'(k) * LN2_Q30, 64'(size));
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (int i = 1; i <= 14; i++) begin
      term = udiv64((term * y) >> 30, 64'(i));
      sum  = sum + term;
    end
    return sum[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/fmm_route_mem.sv
// Route table storage: one write port and one read port with registered data.
// Depends on fmm_pkg for the route entry type.
`default_nettype none

module fmm_route_mem
  import fmm_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire route_t        wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output route_t             rdata_o
);

  route_t mem_q [DEPTH];
  route_t rdata_q;

  // Synchronous write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Synchronous read with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/fmm_exp_rom.sv
// Constant table of 2^(f/SIZE) in Q.30 with a registered read.
// Depends on fmm_pkg for the entry builder.
`default_nettype none

module fmm_exp_rom
  import fmm_pkg::*;
#(
  parameter int SIZE = 256,
  parameter int AW   = 8
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [AW-1:0] addr_i,
  output logic [31:0]        data_o
);

  logic [31:0] rom_w [SIZE];
  logic [31:0] data_q;

  // Table contents are fixed at elaboration.
  for (genvar g = 0; g < SIZE; g++) begin : g_rom
    localparam logic [31:0] Entry = exp_entry(g, SIZE);
    assign rom_w[g] = Entry;
  end

  // Registered lookup.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: design/filter_modulation_matrix.sv
// Filter modulation matrix top level, one request at a time. The response loads once the
// output is free: after acceptance for connect, clear, set and read, after the route
// sweep for disconnects and after the sweep and the arithmetic states for a query; the sweep
// reads one route per cycle. The next request enters the cycle after its response loads.
// Reset empties the table, zeroes source levels and the id counter, and sets the mask to 3.
// Depends on fmm_pkg, fmm_route_mem and fmm_exp_rom.
`default_nettype none

module filter_modulation_matrix
  import fmm_pkg::*;
#(
  parameter int MAX_ROUTES     = 16,
  parameter int NUM_SOURCES    = 7,
  parameter int EXP_TABLE_SIZE = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire req_t        in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rsp_t             out_rsp_o
);

  localparam int AW     = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W  = $clog2(MAX_ROUTES + 1);
  localparam int LVL_AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int ACC_W  = 35 + $clog2(MAX_ROUTES + 1);
  localparam int F_W    = $clog2(EXP_TABLE_SIZE);
  localparam int TP_W   = 18 + $clog2(EXP_TABLE_SIZE + 1);
  localparam int T_W    = $clog2(4 * EXP_TABLE_SIZE + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SWEEP = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_EXP   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e                   state_q, state_d;
  req_t                     req_q;
  logic [MASK_W-1:0]        mask_q;
  logic signed [15:0]       levels_q [NUM_SOURCES];
  logic [15:0]              next_id_q;
  logic [CNT_W-1:0]         held_q;
  logic [CNT_W-1:0]         rd_idx_q;
  logic [CNT_W-1:0]         wr_idx_q;
  logic                     rd_vld_q;
  logic                     removed_q;
  logic signed [34:0]       prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [16:0]       m_q;
  logic [2:0]               w_q;
  logic [31:0]              p_lo_q, p_hi_q;
  logic                     res_ok_q;
  logic [15:0]              res_nid_q;
  logic [17:0]              res_modv_q;
  logic signed [15:0]       res_lout_q;
  logic                     out_valid_q;
  rsp_t                     out_rsp_q;

  logic                     accept;
  logic                     out_free;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  route_t                   mem_wdata;
  logic                     mem_re;
  route_t                   rd_data;
  logic                     is_compact;
  logic                     drop;
  logic                     hit_query;
  logic signed [15:0]       raw_lvl;
  logic                     fixed_bip;
  logic signed [17:0]       eff;
  logic signed [34:0]       prod_d;
  logic [MASK_W:0]          mask_ext;
  logic                     src_ok;
  logic                     can_connect;
  route_t                   new_route;
  logic signed [ACC_W-1:0]  acc_cl;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic [16:0]              u_val;
  logic [TP_W-1:0]          t_full;
  logic [T_W-1:0]           t_val;
  logic [2:0]               w_d;
  logic [F_W-1:0]           f_d;
  logic signed [18:0]       lin_sum;
  logic [17:0]              lin_res;
  logic [31:0]              rom_data;
  logic [47:0]              exp_prod;
  logic [5:0]               exp_sh;
  logic [47:0]              exp_res;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // Connect eligibility and the entry it writes.
  assign src_ok      = 32'(in_req_i.source_index) < NUM_SOURCES;
  assign can_connect = (32'(held_q) < MAX_ROUTES) && src_ok;
  always_comb begin
    new_route.source = in_req_i.source_index;
    new_route.target = in_req_i.target_kind;
    new_route.filter = in_req_i.filter_number;
    new_route.remap  = in_req_i.remap_bipolar;
    new_route.depth  = (in_req_i.depth_amount > DEPTH_ONE) ? DEPTH_ONE
                                                           : in_req_i.depth_amount;
    new_route.id     = next_id_q;
  end

  // Sweep stage: decide on the entry whose read data just arrived.
  assign is_compact = (req_q.operation == OP_DISC_ID) || (req_q.operation == OP_DISC_FILT);
  always_comb begin
    if (req_q.operation == OP_DISC_ID) begin
      drop = (rd_data.id == req_q.route_id) && !removed_q;
    end else begin
      drop = (rd_data.filter == req_q.filter_number);
    end
  end
  assign hit_query = (rd_data.target == req_q.target_kind)
                  && (rd_data.filter == req_q.filter_number);

  // Effective source level and its product with the depth.
  assign mask_ext  = {1'b0, mask_q};
  assign raw_lvl   = (32'(rd_data.source) < NUM_SOURCES)
                   ? levels_q[LVL_AW'(rd_data.source)] : 16'sd0;
  assign fixed_bip = mask_ext[rd_data.source];
  assign eff       = (fixed_bip || !rd_data.remap) ? 18'(raw_lvl)
                   : (18'(raw_lvl) <<< 1) - 18'(LVL_ONE);
  assign prod_d    = 35'(eff) * 35'($signed({1'b0, rd_data.depth}));

  // Memory port selection: connect writes at the end, compaction writes behind the reads.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(held_q);
    mem_wdata = new_route;
    if (accept && (in_req_i.operation == OP_CONNECT) && can_connect) begin
      mem_we = 1'b1;
    end else if (rd_vld_q && is_compact && !drop) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(wr_idx_q);
      mem_wdata = rd_data;
    end
  end
  assign mem_re = (state_q == S_SWEEP) && (rd_idx_q < held_q);

  fmm_route_mem #(
    .DEPTH (MAX_ROUTES),
    .AW    (AW)
  ) u_route_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (AW'(rd_idx_q)),
    .rdata_o (rd_data)
  );

  // Sum clamp and rounding to a Q0.15 modulation amount.
  always_comb begin
    if (acc_q > ACC_W'(SUM_LIMIT)) begin
      acc_cl = ACC_W'(SUM_LIMIT);
    end else if (acc_q < -ACC_W'(SUM_LIMIT)) begin
      acc_cl = -ACC_W'(SUM_LIMIT);
    end else begin
      acc_cl = acc_q;
    end
    acc_rnd = (acc_cl + ACC_W'(ROUND_HALF)) >>> M_SHIFT;
  end

  // Exponent split into whole octaves and table fraction.
  always_comb begin
    u_val  = 17'(m_q + 17'(M_OFFSET));
    t_full = TP_W'(u_val) * TP_W'(EXP_TABLE_SIZE);
    t_val  = T_W'(t_full >> M_SHIFT);
    w_d    = 3'd0;
    f_d    = F_W'(t_val);
    for (int k = 1; k <= 4; k++) begin
      if (32'(t_val) >= k * EXP_TABLE_SIZE) begin
        w_d = 3'(k);
        f_d = F_W'(32'(t_val) - k * EXP_TABLE_SIZE);
      end
    end
  end

  fmm_exp_rom #(
    .SIZE (EXP_TABLE_SIZE),
    .AW   (F_W)
  ) u_exp_rom (
    .clk_i  (clk_i),
    .en_i   (state_q == S_EXP),
    .addr_i (f_d),
    .data_o (rom_data)
  );

  // Linear targets: base plus amount, clamped to 0..1.0.
  always_comb begin
    lin_sum = 19'($signed({1'b0, req_q.base_value})) + 19'(m_q);
    if (lin_sum < 19'sd0) begin
      lin_res = '0;
    end else if (lin_sum > 19'(OUT_MAX)) begin
      lin_res = 18'(OUT_MAX);
    end else begin
      lin_res = 18'(lin_sum);
    end
  end

  // Cutoff: recombine the partial products and scale by the octave count.
  assign exp_prod = {p_hi_q, 16'd0} + 48'(p_lo_q);
  assign exp_sh   = 6'(EXP_SHIFT) - 6'(w_q);
  assign exp_res  = exp_prod >> exp_sh;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((in_req_i.operation == OP_DISC_ID) || (in_req_i.operation == OP_DISC_FILT)
              || (in_req_i.operation == OP_QUERY)) begin
            state_d = S_SWEEP;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SWEEP: begin
        if (rd_idx_q >= held_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = is_compact ? S_DONE : S_MOD;
        end
      end
      S_MOD: state_d = S_EXP;
      S_EXP: state_d = (req_q.target_kind == TGT_CUTOFF) ? S_MUL : S_DONE;
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= MASK_W'(3);
      next_id_q   <= '0;
      held_q      <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      removed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        levels_q[s] <= '0;
      end
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= mem_re;
      prod_vld_q <= rd_vld_q && !is_compact && hit_query;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (mem_re) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (rd_vld_q && is_compact) begin
        if (drop) begin
          removed_q <= 1'b1;
        end else begin
          wr_idx_q <= wr_idx_q + 1'b1;
        end
      end
      if ((state_q == S_DRAIN) && (state_d == S_DONE)) begin
        held_q <= wr_idx_q;
      end
      if (accept) begin
        rd_idx_q  <= '0;
        wr_idx_q  <= '0;
        removed_q <= 1'b0;
        case (in_req_i.operation)
          OP_CONNECT: begin
            if (can_connect) begin
              held_q    <= held_q + 1'b1;
              next_id_q <= next_id_q + 16'd1;
            end
          end
          OP_CLEAR: held_q <= '0;
          OP_SET_SRC: begin
            if (src_ok) begin
              levels_q[LVL_AW'(in_req_i.source_index)] <= in_req_i.level_in;
            end
          end
          default: ;
        endcase
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and response registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= in_req_i;
      acc_q      <= '0;
      res_ok_q   <= 1'b0;
      res_nid_q  <= '0;
      res_modv_q <= '0;
      res_lout_q <= '0;
      case (in_req_i.operation)
        OP_CONNECT: begin
          if (can_connect) begin
            res_ok_q  <= 1'b1;
            res_nid_q <= next_id_q;
          end
        end
        OP_CLEAR: res_ok_q <= (held_q != '0);
        OP_READ_SRC: begin
          if (src_ok) begin
            res_lout_q <= levels_q[LVL_AW'(in_req_i.source_index)];
          end
        end
        default: ;
      endcase
    end
    if (rd_vld_q) begin
      prod_q <= prod_d;
    end
    if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if ((state_q == S_DRAIN) && (state_d == S_DONE)) begin
      res_ok_q <= removed_q;
    end
    if (state_q == S_MOD) begin
      m_q <= 17'(acc_rnd);
    end
    if (state_q == S_EXP) begin
      w_q        <= w_d;
      res_modv_q <= lin_res;
    end
    if (state_q == S_MUL) begin
      p_lo_q <= 32'(req_q.base_value) * 32'(rom_data[15:0]);
      p_hi_q <= 32'(req_q.base_value) * 32'(rom_data[31:16]);
    end
    if (state_q == S_SUM) begin
      res_modv_q <= exp_res[17:0];
    end
    if ((state_q == S_DONE) && out_free) begin
      out_rsp_q.ok              <= res_ok_q;
      out_rsp_q.new_route_id    <= res_nid_q;
      out_rsp_q.modulated_value <= res_modv_q;
      out_rsp_q.level_out       <= res_lout_q;
      out_rsp_q.route_count     <= 5'(held_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The table never holds more routes than it has entries.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= MAX_ROUTES)
    else $error("route count exceeds table size");

  // A compaction write never lands ahead of the entries still to be read.
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && is_compact) |-> (wr_idx_q < rd_idx_q))
    else $error("compaction write overtakes read pointer");

  // A response appears only after the sequencer finished a request.
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside completion");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the filter modulation matrix.
// It drives requests and checks each response against a typed row or a behavioral model of
// the route table, source levels and query arithmetic. Depends on fmm_pkg.
`default_nettype none

module testbench;
  import fmm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int         N_ROUTES  = 16;
  localparam int         N_SRC     = 7;
  localparam int         FRAC_SIZE = 256;
  localparam int         CYCLE_LIMIT = 2000000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         REQ_W     = $bits(req_t);

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  req_t       in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  rsp_t       out_rsp_o;

  // Model state of the matrix.
  route_t             model_routes[$];
  logic signed [15:0] model_levels[N_SRC];
  logic [15:0]        model_next_id;
  logic [6:0]         model_mask;
  longint unsigned    pow2_frac_q30[FRAC_SIZE];

  rsp_t      pending_rsp[$];
  stim_row_t directed[$];
  int        errors = 0;
  int        cycles = 0;
  int        burst_left = 0;

  filter_modulation_matrix dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Fraction table of 2^(k/256) in Q.30 from a truncated Taylor series.
  initial begin
    longint unsigned y, term, acc;
    for (int k = 0; k < FRAC_SIZE; k++) begin
      y    = (longint'(k) * 64'd744261118) / FRAC_SIZE;
      term = 64'd1073741824;
      acc  = term;
      for (int i = 1; i <= 14; i++) begin
        term = ((term * y) >> 30) / i;
        acc  = acc + term;
      end
      pow2_frac_q30[k] = acc;
    end
  end

  // Source level as seen by a route, after the optional unipolar remap.
  function automatic longint route_level(route_t rt);
    longint raw;
    raw = (rt.source < N_SRC) ? longint'(model_levels[rt.source]) : 0;
    if (model_mask[rt.source] || !rt.remap) return raw;
    return raw * 2 - 16384;
  endfunction

  // Apply one request to the model and return the response it produces.
  function automatic rsp_t matrix_step(req_t r);
    rsp_t            o;
    route_t          rt;
    longint          acc;
    int              m, v, t, w, f, i;
    longint unsigned prod;
    o = '0;
    case (r.operation)
      OP_CONNECT: begin
        if (model_routes.size() < N_ROUTES && r.source_index < N_SRC) begin
          rt.source = r.source_index;
          rt.target = r.target_kind;
          rt.filter = r.filter_number;
          rt.remap  = r.remap_bipolar;
          rt.depth  = (r.depth_amount > DEPTH_ONE) ? DEPTH_ONE : r.depth_amount;
          rt.id     = model_next_id;
          model_routes = {model_routes, rt};
          o.new_route_id = model_next_id;
          model_next_id  = model_next_id + 16'd1;
          o.ok = 1'b1;
        end
      end
      OP_DISC_ID: begin
        foreach (model_routes[k]) begin
          if (!o.ok && model_routes[k].id == r.route_id) begin
            model_routes.delete(k);
            o.ok = 1'b1;
            break;
          end
        end
      end
      OP_DISC_FILT: begin
        i = 0;
        while (i < model_routes.size()) begin
          if (model_routes[i].filter == r.filter_number) begin
            model_routes.delete(i);
            o.ok = 1'b1;
          end else begin
            i++;
          end
        end
      end
      OP_CLEAR: begin
        o.ok = model_routes.size() > 0;
        model_routes.delete();
      end
      OP_SET_SRC: begin
        if (r.source_index < N_SRC) model_levels[r.source_index] = r.level_in;
      end
      OP_QUERY: begin
        acc = 0;
        foreach (model_routes[k]) begin
          if (model_routes[k].target == r.target_kind &&
              model_routes[k].filter == r.filter_number)
            acc += route_level(model_routes[k]) * longint'(model_routes[k].depth);
        end
        if (acc > 536870912) acc = 536870912;
        if (acc < -536870912) acc = -536870912;
        m = int'((acc + 536870912 + 8192) / 16384) - 32768;
        if (r.target_kind == TGT_CUTOFF) begin
          t = (m + 32768) / 64;
          w = t / FRAC_SIZE;
          f = t % FRAC_SIZE;
          prod = longint'(r.base_value) * pow2_frac_q30[f];
          o.modulated_value = 18'(prod >> (32 - w));
        end else begin
          v = int'(r.base_value) + m;
          if (v < 0) v = 0;
          if (v > 32768) v = 32768;
          o.modulated_value = 18'(v);
        end
      end
      OP_READ_SRC: begin
        if (r.source_index < N_SRC) o.level_out = model_levels[r.source_index];
      end
      default: ;
    endcase
    o.route_count = 5'(model_routes.size());
    return o;
  endfunction

  function automatic req_t mk_req(logic [2:0] op, int src, int tgt, int flt, int depth,
                                  int remap, int rid, int lvl, int base);
    req_t r;
    r = '{op, 3'(src), 2'(tgt), 3'(flt), 16'(depth), 1'(remap), 16'(rid), 16'(lvl),
          16'(base)};
    return r;
  endfunction

  function automatic rsp_t mk_rsp(int ok, int nid, int modv, int lout, int cnt);
    rsp_t o;
    o = '{1'(ok), 16'(nid), 18'(modv), 16'(lout), 5'(cnt)};
    return o;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(req_t r, bit typed, rsp_t want);
    stim_row_t row;
    row.r     = r;
    row.typed = typed;
    row.want  = want;
    directed  = {directed, row};
  endfunction

  // Send one request: bursts of back-to-back requests with random gaps between.
  task automatic send_request(req_t r, bit typed, rsp_t want);
    rsp_t model_rsp;
    rsp_t expect_rsp;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_rsp  = matrix_step(r);
    expect_rsp = typed ? want : model_rsp;
    pending_rsp = {pending_rsp, expect_rsp};
  endtask

  // Drop valid and let every outstanding response drain.
  task automatic drain_responses();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [6:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_mask = value;
  endtask

  // Random request, weighted toward connects and queries that hit routes.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
    r.source_index  = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    r.filter_number = 3'($urandom_range(0, 3)) | ($urandom_range(0, 3) == 0 ? 3'd4 : 3'd0);
    if ($urandom_range(0, 2) != 0) r.depth_amount = 16'($urandom_range(0, 32768));
    if ($urandom_range(0, 2) != 0) r.level_in = 16'($urandom_range(0, 32768) - 16384);
    if ($urandom_range(0, 2) != 0) r.route_id = model_next_id - 16'($urandom_range(1, 24));
    pick = $urandom_range(0, 99);
    if (pick < 30)      r.operation = OP_CONNECT;
    else if (pick < 55) r.operation = OP_QUERY;
    else if (pick < 70) r.operation = OP_SET_SRC;
    else if (pick < 77) r.operation = OP_READ_SRC;
    else if (pick < 88) r.operation = OP_DISC_ID;
    else if (pick < 95) r.operation = OP_DISC_FILT;
    else if (pick < 98) r.operation = OP_CLEAR;
    else                r.operation = OP_UNUSED;
    return r;
  endfunction

  // Response side: stall pattern that steps through four modes in turn.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response %p", $time, out_rsp_o);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o.ok !== want.ok) begin
          $display("%0t: ok expected %0d actual %0d", $time, want.ok, out_rsp_o.ok);
          errors++;
        end
        if (out_rsp_o.new_route_id !== want.new_route_id) begin
          $display("%0t: new_route_id expected %0d actual %0d", $time,
                   want.new_route_id, out_rsp_o.new_route_id);
          errors++;
        end
        if (out_rsp_o.modulated_value !== want.modulated_value) begin
          $display("%0t: modulated_value expected %0d actual %0d", $time,
                   want.modulated_value, out_rsp_o.modulated_value);
          errors++;
        end
        if (out_rsp_o.level_out !== want.level_out) begin
          $display("%0t: level_out expected %0d actual %0d", $time,
                   want.level_out, out_rsp_o.level_out);
          errors++;
        end
        if (out_rsp_o.route_count !== want.route_count) begin
          $display("%0t: route_count expected %0d actual %0d", $time,
                   want.route_count, out_rsp_o.route_count);
          errors++;
        end
      end
    end
    case ((cycles / 64) % 4)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) == 1);
      2:       out_ready_i <= (cycles % 5 == 0);
      default: out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Main sequence.
  initial begin
    logic [6:0] phase_masks[4];
    for (int s = 0; s < N_SRC; s++) model_levels[s] = '0;
    model_next_id = '0;
    model_mask    = 7'd3;

    // Directed rows; typed responses where they are plain to see.
    add_row(mk_req(OP_READ_SRC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0));
    add_row(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1000), 1'b1, mk_rsp(0, 0, 1000, 0, 0));
    add_row(mk_req(OP_SET_SRC, 0, 0, 0, 0, 0, 0, 16384, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0));
    add_row(mk_req(OP_SET_SRC, 2, 0, 0, 0, 0, 0, 8192, 0), 1'b0, '0);
    add_row(mk_req(OP_SET_SRC, 6, 0, 0, 0, 0, 0, -32768, 0), 1'b0, '0);
    add_row(mk_req(OP_READ_SRC, 6, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_rsp(0, 0, 0, -32768, 0));
    add_row(mk_req(OP_SET_SRC, 7, 0, 0, 0, 0, 0, 12345, 0), 1'b0, '0);
    add_row(mk_req(OP_READ_SRC, 7, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0));
    add_row(mk_req(OP_CONNECT, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0), 1'b1,
            mk_rsp(1, 0, 0, 0, 1));
    add_row(mk_req(OP_CONNECT, 2, 1, 1, 16384, 1, 0, 0, 0), 1'b1, mk_rsp(1, 1, 0, 0, 2));
    add_row(mk_req(OP_CONNECT, 7, 2, 2, 100, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 2));
    add_row(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
            mk_rsp(0, 0, 262140, 0, 2));
    add_row(mk_req(OP_QUERY, 0, 1, 1, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_SET_SRC, 0, 0, 0, 0, 0, 0, -16384, 0), 1'b0, '0);
    add_row(mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
            mk_rsp(0, 0, 16383, 0, 2));
    add_row(mk_req(OP_DISC_ID, 0, 0, 0, 0, 0, 1, 0, 0), 1'b1, mk_rsp(1, 0, 0, 0, 1));
    add_row(mk_req(OP_DISC_ID, 0, 0, 0, 0, 0, 1, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 1));
    add_row(mk_req(OP_DISC_FILT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(1, 0, 0, 0, 0));
    add_row(mk_req(OP_DISC_FILT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0));
    add_row(mk_req(OP_CONNECT, 6, 3, 7, 0, 1, 0, 0, 0), 1'b1, mk_rsp(1, 2, 0, 0, 1));
    add_row(mk_req(OP_QUERY, 0, 3, 7, 0, 0, 0, 0, 32768), 1'b0, '0);
    add_row(mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(1, 0, 0, 0, 0));
    add_row(mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0));
    add_row(mk_req(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0));
    add_row(mk_req(OP_QUERY, 0, 2, 3, 0, 0, 0, 0, 16'hFFFF), 1'b1,
            mk_rsp(0, 0, 32768, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_request(directed[k].r, directed[k].typed, directed[k].want);
    drain_responses();

    // Random phases, each under its own bipolar mask; the drain before every
    // mask write also holds the sender until all responses are back.
    phase_masks[0] = 7'd3;
    phase_masks[1] = 7'd0;
    phase_masks[2] = 7'h7F;
    phase_masks[3] = 7'($urandom_range(0, 127));
    for (int p = 0; p < 4; p++) begin
      write_mask(phase_masks[p]);
      repeat (232) send_request(random_request(), 1'b0, '0);
      drain_responses();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
